// ----- rtl/i2cms_pkg.sv -----
// Shared types and constants for the I2C master bit sequencer.
package i2cms_pkg;

    // Command codes carried in req_type.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STOP  = 2'd2;
    localparam logic [1:0] REQ_WRITE = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_SETUP = 2'd0;
    localparam logic [1:0] CFG_HIGH  = 2'd1;
    localparam logic [1:0] CFG_LOW   = 2'd2;

    // Width of the configuration address bus.
    localparam int unsigned ADDR_W = 4;

    // Reset values of the timing registers.
    localparam logic [7:0] SETUP_TICKS_RST = 8'd3;
    localparam logic [7:0] HIGH_TICKS_RST  = 8'd5;
    localparam logic [7:0] LOW_TICKS_RST   = 8'd2;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_ST_A   = 4'd1,
        PH_ST_B   = 4'd2,
        PH_ST_C   = 4'd3,
        PH_SP_A   = 4'd4,
        PH_SP_B   = 4'd5,
        PH_SP_C   = 4'd6,
        PH_W_SET  = 4'd7,
        PH_W_HIGH = 4'd8,
        PH_W_LOW  = 4'd9,
        PH_A_SET  = 4'd10,
        PH_A_HIGH = 4'd11,
        PH_A_LOW  = 4'd12
    } t_phase;

    typedef struct packed {
        logic [7:0] setup_ticks;
        logic [7:0] high_ticks;
        logic [7:0] low_ticks;
    } t_timing;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] wr_byte;
        logic       sda_in;
    } t_cmd;

    typedef struct packed {
        logic scl_release;
        logic sda_release;
        logic busy_res;
        logic done_res;
        logic ack_seen;
    } t_result;

endpackage

// ----- rtl/i2cms_if.sv -----
// Valid/ready channel interfaces for commands and per-tick results.
interface i2cms_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] wr_byte;
    logic       sda_in;

    modport source (output valid, req_type, wr_byte, sda_in, input ready);
    modport sink   (input valid, req_type, wr_byte, sda_in, output ready);
endinterface

interface i2cms_res_if;
    logic valid;
    logic ready;
    logic scl_release;
    logic sda_release;
    logic busy_res;
    logic done_res;
    logic ack_seen;

    modport source (output valid, scl_release, sda_release, busy_res, done_res, ack_seen,
                    input ready);
    modport sink   (input valid, scl_release, sda_release, busy_res, done_res, ack_seen,
                    output ready);
endinterface

// ----- rtl/i2cms_cfg.sv -----
// APB-style register block holding the three phase-length registers.
module i2cms_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [i2cms_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output i2cms_pkg::t_timing             o_timing
);

    logic [7:0] r_setup_ticks;
    logic [7:0] r_high_ticks;
    logic [7:0] r_low_ticks;
    logic       wr_en;
    logic [1:0] reg_idx;
    logic [7:0] rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup_ticks <= i2cms_pkg::SETUP_TICKS_RST;
            r_high_ticks  <= i2cms_pkg::HIGH_TICKS_RST;
            r_low_ticks   <= i2cms_pkg::LOW_TICKS_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                i2cms_pkg::CFG_SETUP: r_setup_ticks <= pwdata[7:0];
                i2cms_pkg::CFG_HIGH:  r_high_ticks  <= pwdata[7:0];
                i2cms_pkg::CFG_LOW:   r_low_ticks   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            i2cms_pkg::CFG_SETUP: rd_val = r_setup_ticks;
            i2cms_pkg::CFG_HIGH:  rd_val = r_high_ticks;
            i2cms_pkg::CFG_LOW:   rd_val = r_low_ticks;
            default:              rd_val = 8'd0;
        endcase
    end

    assign prdata = {24'd0, rd_val};

    assign o_timing.setup_ticks = r_setup_ticks;
    assign o_timing.high_ticks  = r_high_ticks;
    assign o_timing.low_ticks   = r_low_ticks;

endmodule

// ----- rtl/i2cms_core.sv -----
// Bus-phase state machine that advances one tick per step and forms its result.
module i2cms_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  i2cms_pkg::t_cmd     i_cmd,
    input  i2cms_pkg::t_timing  i_timing,
    output i2cms_pkg::t_result  o_result
);

    i2cms_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_tick_count, n_tick_count;
    logic [3:0] r_bit_count, n_bit_count;
    logic [7:0] r_shift_byte, n_shift_byte;
    logic       r_scl_line, n_scl_line;
    logic       r_sda_line, n_sda_line;
    logic       r_ack_latch, n_ack_latch;

    logic [7:0] phase_len;
    logic       last_tick;
    logic [3:0] bit_inc;
    logic       done;
    logic       ack_out;

    always_comb begin
        unique case (r_phase)
            i2cms_pkg::PH_W_HIGH, i2cms_pkg::PH_A_HIGH: phase_len = i_timing.high_ticks;
            i2cms_pkg::PH_W_LOW, i2cms_pkg::PH_A_LOW:   phase_len = i_timing.low_ticks;
            default:                                    phase_len = i_timing.setup_ticks;
        endcase
    end

    // A length of zero behaves as one tick.
    assign last_tick = ({1'b0, r_tick_count} + 9'd1) >= {1'b0, phase_len};
    assign bit_inc   = r_bit_count + 4'd1;

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            i2cms_pkg::PH_IDLE: begin
                unique case (i_cmd.req_type)
                    i2cms_pkg::REQ_START: n_phase = i2cms_pkg::PH_ST_A;
                    i2cms_pkg::REQ_STOP:  n_phase = i2cms_pkg::PH_SP_A;
                    i2cms_pkg::REQ_WRITE: n_phase = i2cms_pkg::PH_W_SET;
                    default:              n_phase = i2cms_pkg::PH_IDLE;
                endcase
            end
            i2cms_pkg::PH_ST_A:   if (last_tick) n_phase = i2cms_pkg::PH_ST_B;
            i2cms_pkg::PH_ST_B:   if (last_tick) n_phase = i2cms_pkg::PH_ST_C;
            i2cms_pkg::PH_ST_C:   if (last_tick) n_phase = i2cms_pkg::PH_IDLE;
            i2cms_pkg::PH_SP_A:   if (last_tick) n_phase = i2cms_pkg::PH_SP_B;
            i2cms_pkg::PH_SP_B:   if (last_tick) n_phase = i2cms_pkg::PH_SP_C;
            i2cms_pkg::PH_SP_C:   if (last_tick) n_phase = i2cms_pkg::PH_IDLE;
            i2cms_pkg::PH_W_SET:  if (last_tick) n_phase = i2cms_pkg::PH_W_HIGH;
            i2cms_pkg::PH_W_HIGH: if (last_tick) n_phase = i2cms_pkg::PH_W_LOW;
            i2cms_pkg::PH_W_LOW: begin
                if (last_tick) begin
                    n_phase = bit_inc[3] ? i2cms_pkg::PH_A_SET : i2cms_pkg::PH_W_SET;
                end
            end
            i2cms_pkg::PH_A_SET:  if (last_tick) n_phase = i2cms_pkg::PH_A_HIGH;
            i2cms_pkg::PH_A_HIGH: if (last_tick) n_phase = i2cms_pkg::PH_A_LOW;
            i2cms_pkg::PH_A_LOW:  if (last_tick) n_phase = i2cms_pkg::PH_IDLE;
            default:              n_phase = i2cms_pkg::PH_IDLE;
        endcase
    end

    // Counters, shifter, line levels and the per-tick flags.
    always_comb begin
        n_tick_count = r_tick_count;
        n_bit_count  = r_bit_count;
        n_shift_byte = r_shift_byte;
        n_scl_line   = r_scl_line;
        n_sda_line   = r_sda_line;
        n_ack_latch  = r_ack_latch;
        done         = 1'b0;
        ack_out      = 1'b0;
        if (r_phase == i2cms_pkg::PH_IDLE) begin
            unique case (i_cmd.req_type)
                i2cms_pkg::REQ_START: begin
                    n_tick_count = 8'd0;
                    n_sda_line   = 1'b1;
                end
                i2cms_pkg::REQ_STOP: begin
                    n_tick_count = 8'd0;
                    n_scl_line   = 1'b0;
                    n_sda_line   = 1'b0;
                end
                i2cms_pkg::REQ_WRITE: begin
                    n_tick_count = 8'd0;
                    n_shift_byte = i_cmd.wr_byte;
                    n_bit_count  = 4'd0;
                    n_ack_latch  = 1'b0;
                    n_scl_line   = 1'b0;
                    n_sda_line   = i_cmd.wr_byte[7];
                end
                default: ;
            endcase
        end else if (!last_tick) begin
            n_tick_count = r_tick_count + 8'd1;
        end else begin
            n_tick_count = 8'd0;
            unique case (r_phase)
                i2cms_pkg::PH_ST_A:   n_scl_line = 1'b1;
                i2cms_pkg::PH_ST_B:   n_sda_line = 1'b0;
                i2cms_pkg::PH_ST_C: begin
                    n_scl_line = 1'b0;
                    done       = 1'b1;
                end
                i2cms_pkg::PH_SP_A:   n_scl_line = 1'b1;
                i2cms_pkg::PH_SP_B:   n_sda_line = 1'b1;
                i2cms_pkg::PH_SP_C:   done = 1'b1;
                i2cms_pkg::PH_W_SET:  n_scl_line = 1'b1;
                i2cms_pkg::PH_W_HIGH: n_scl_line = 1'b0;
                i2cms_pkg::PH_W_LOW: begin
                    n_shift_byte = {r_shift_byte[6:0], 1'b0};
                    n_bit_count  = bit_inc;
                    n_scl_line   = 1'b0;
                    // After the eighth bit SDA is released for the acknowledge.
                    n_sda_line   = bit_inc[3] ? 1'b1 : r_shift_byte[6];
                end
                i2cms_pkg::PH_A_SET:  n_scl_line = 1'b1;
                i2cms_pkg::PH_A_HIGH: begin
                    n_ack_latch = ~i_cmd.sda_in;
                    n_scl_line  = 1'b0;
                end
                i2cms_pkg::PH_A_LOW: begin
                    done    = 1'b1;
                    ack_out = r_ack_latch;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= i2cms_pkg::PH_IDLE;
            r_tick_count <= 8'd0;
            r_bit_count  <= 4'd0;
            r_shift_byte <= 8'd0;
            r_scl_line   <= 1'b1;
            r_sda_line   <= 1'b1;
            r_ack_latch  <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_bit_count  <= n_bit_count;
            r_shift_byte <= n_shift_byte;
            r_scl_line   <= n_scl_line;
            r_sda_line   <= n_sda_line;
            r_ack_latch  <= n_ack_latch;
        end
    end

    assign o_result.scl_release = n_scl_line;
    assign o_result.sda_release = n_sda_line;
    assign o_result.busy_res    = (n_phase != i2cms_pkg::PH_IDLE);
    assign o_result.done_res    = done;
    assign o_result.ack_seen    = ack_out;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.done_res |-> !o_result.busy_res)
        else $error("sequence finished while still reported busy");

    a_ack_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.ack_seen |-> o_result.done_res)
        else $error("acknowledge reported outside a finishing tick");

    a_scl_high_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == i2cms_pkg::PH_W_HIGH || r_phase == i2cms_pkg::PH_A_HIGH |-> r_scl_line)
        else $error("SCL driven low during a clock-high phase");

    a_sda_free_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == i2cms_pkg::PH_A_SET || r_phase == i2cms_pkg::PH_A_HIGH |-> r_sda_line)
        else $error("SDA not released during the acknowledge pulse");

    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= 4'd8)
        else $error("bit counter past eight");

    a_tick_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (n_phase != r_phase) |=> r_tick_count == 8'd0)
        else $error("tick counter not restarted on a phase change");

endmodule

// ----- rtl/i2c_master_bit_sequencer_unit.sv -----
// Top level of the tick-driven I2C master bit sequencer.
//
// Usage: every transfer on the command channel (i_cmd) is one tick of the bus
// timebase. It carries a request code (tick only, start, stop, write byte),
// the byte to send on a write and the sampled SDA level. For every command
// transfer exactly one result transfer leaves on o_res, in order, carrying the
// SCL and SDA drive levels after that tick (1 = released), a busy flag, a done
// flag on the finishing tick, and the acknowledge seen on the done tick of a
// write. Requests arriving while a sequence runs are ignored.
//
// A command is captured in an input register; the phase state machine then
// evaluates it and, once the output register is free, its result is written
// to the output register. Throughput is one command per cycle while o_res
// is not stalled.
//
// The receiver may stall o_res at any time: the output register holds its
// result and the input register holds one further command, after which
// i_cmd.ready drops until o_res moves again. Reset (synchronous, active low)
// empties both registers, returns the bus lines to released and loads the
// timing registers with 3, 5 and 2 ticks. The user writes the timing registers
// through the APB-style port only while no command is in flight (not enforced).
module i2c_master_bit_sequencer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    i2cms_cmd_if.sink                     i_cmd,
    i2cms_res_if.source                   o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [i2cms_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    i2cms_pkg::t_timing timing;
    i2cms_pkg::t_result step_result;

    logic               r_in_valid;
    i2cms_pkg::t_cmd    r_in_cmd;
    logic               r_out_valid;
    i2cms_pkg::t_result r_out_result;
    logic               step;

    i2cms_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_timing (timing)
    );

    // A held command moves into the result register when that register is
    // empty or is being emptied in the same cycle.
    assign step        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ready && i_cmd.valid) begin
            r_in_cmd.req_type <= i_cmd.req_type;
            r_in_cmd.wr_byte  <= i_cmd.wr_byte;
            r_in_cmd.sda_in   <= i_cmd.sda_in;
        end
    end

    i2cms_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cmd    (r_in_cmd),
        .i_timing (timing),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_result <= step_result;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.scl_release = r_out_result.scl_release;
    assign o_res.sda_release = r_out_result.sda_release;
    assign o_res.busy_res    = r_out_result.busy_res;
    assign o_res.done_res    = r_out_result.done_res;
    assign o_res.ack_seen    = r_out_result.ack_seen;

endmodule
